[sv/pfc_pkg.sv]
// pfc_pkg: shared constants, types and controller states of the frame centroid block
`default_nettype none

package pfc_pkg;

  // frame geometry and number formats
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int FORCE_BITS = 12;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int POS_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CFG_W   = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1);
  localparam int TOTAL_W = FORCE_BITS + COL_W + ROW_W;
  localparam int WSUM_W  = TOTAL_W + POS_W;
  localparam int CENT_W  = POS_W + FRAC_BITS;
  localparam int DIVD_W  = WSUM_W + FRAC_BITS;
  localparam int STEP_W  = (CENT_W > 1) ? $clog2(CENT_W) : 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIV,
    ST_HOLD
  } pfc_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // take one sample beat into the accumulators
    logic load;     // move frame sums into the dividers, clear accumulators
    logic step;     // one restoring division step on both centroids
    logic publish;  // load the result register
  } pfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_cell;  // current cell closes the frame
  } pfc_sts_t;

endpackage

`default_nettype wire

[sv/pfc_stream_if.sv]
// pfc_stream_if: valid/ready channels for force samples and frame results
`default_nettype none

interface pfc_sample_if;
  import pfc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FORCE_BITS-1:0] force_sample;

  modport source (output valid, output force_sample, input ready);
  modport sink   (input valid, input force_sample, output ready);
endinterface

interface pfc_result_if;
  import pfc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FORCE_BITS-1:0] peak_force;
  logic [TOTAL_W-1:0]    total_force;
  logic [CENT_W-1:0]     centroid_x;
  logic [CENT_W-1:0]     centroid_y;
  logic                  empty_frame;

  modport source (output valid, output peak_force, output total_force,
                  output centroid_x, output centroid_y, output empty_frame,
                  input ready);
  modport sink   (input valid, input peak_force, input total_force,
                  input centroid_x, input centroid_y, input empty_frame,
                  output ready);
endinterface

`default_nettype wire

[sv/pfc_datapath.sv]
// pfc_datapath: frame counters, accumulators, two restoring dividers and result register
`default_nettype none

module pfc_datapath
  import pfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic [FORCE_BITS-1:0] force_sample,
  input  wire pfc_cmd_t              cmd,
  output pfc_sts_t                   sts,
  output logic [FORCE_BITS-1:0]      peak_force,
  output logic [TOTAL_W-1:0]         total_force,
  output logic [CENT_W-1:0]          centroid_x,
  output logic [CENT_W-1:0]          centroid_y,
  output logic                       empty_frame
);

  logic [CFG_W-1:0]      frame_cols;
  logic [CFG_W-1:0]      frame_rows;
  logic [COL_W-1:0]      col_count;
  logic [ROW_W-1:0]      row_count;
  logic [FORCE_BITS-1:0] running_peak;
  logic [TOTAL_W-1:0]    running_total;
  logic [WSUM_W-1:0]     weighted_x_sum;
  logic [WSUM_W-1:0]     weighted_y_sum;

  logic [FORCE_BITS-1:0] div_peak;
  logic [TOTAL_W-1:0]    div_total;
  logic [TOTAL_W-1:0]    rem_x;
  logic [TOTAL_W-1:0]    rem_y;
  logic [CENT_W-1:0]     quo_x;
  logic [CENT_W-1:0]     quo_y;

  logic [CFG_W-1:0]            cols_eff;
  logic [CFG_W-1:0]            rows_eff;
  logic                        last_col;
  logic                        last_row;
  logic [COL_W+FORCE_BITS-1:0] prod_x;
  logic [ROW_W+FORCE_BITS-1:0] prod_y;
  logic [DIVD_W-1:0]           half_total;
  logic [DIVD_W-1:0]           dvd_x;
  logic [DIVD_W-1:0]           dvd_y;
  logic [TOTAL_W:0]            trial_x;
  logic [TOTAL_W:0]            trial_y;
  logic                        ge_x;
  logic                        ge_y;
  logic [TOTAL_W:0]            diff_x;
  logic [TOTAL_W:0]            diff_y;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= CFG_W'(MAX_COLS);
      frame_rows <= CFG_W'(MAX_ROWS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COLS: frame_cols <= cfg_data;
        REG_FRAME_ROWS: frame_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // limits clamped to 1..max
  always_comb begin
    if (frame_cols == '0)                    cols_eff = CFG_W'(1);
    else if (frame_cols > CFG_W'(MAX_COLS))  cols_eff = CFG_W'(MAX_COLS);
    else                                     cols_eff = frame_cols;
    if (frame_rows == '0)                    rows_eff = CFG_W'(1);
    else if (frame_rows > CFG_W'(MAX_ROWS))  rows_eff = CFG_W'(MAX_ROWS);
    else                                     rows_eff = frame_rows;
  end

  // end of row and end of frame detection
  assign last_col = (CFG_W'(col_count) + CFG_W'(1)) >= cols_eff;
  assign last_row = (CFG_W'(row_count) + CFG_W'(1)) >= rows_eff;
  assign sts.last_cell = last_col && last_row;

  // position weighted force
  assign prod_x = (COL_W+FORCE_BITS)'(col_count) * (COL_W+FORCE_BITS)'(force_sample);
  assign prod_y = (ROW_W+FORCE_BITS)'(row_count) * (ROW_W+FORCE_BITS)'(force_sample);

  // counters and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count      <= '0;
      row_count      <= '0;
      running_peak   <= '0;
      running_total  <= '0;
      weighted_x_sum <= '0;
      weighted_y_sum <= '0;
    end else if (cmd.load) begin
      running_peak   <= '0;
      running_total  <= '0;
      weighted_x_sum <= '0;
      weighted_y_sum <= '0;
    end else if (cmd.accept) begin
      if (force_sample > running_peak) running_peak <= force_sample;
      running_total  <= running_total + TOTAL_W'(force_sample);
      weighted_x_sum <= weighted_x_sum + WSUM_W'(prod_x);
      weighted_y_sum <= weighted_y_sum + WSUM_W'(prod_y);
      if (!last_col) begin
        col_count <= col_count + COL_W'(1);
      end else begin
        col_count <= '0;
        if (!last_row) row_count <= row_count + ROW_W'(1);
        else           row_count <= '0;
      end
    end
  end

  // rounded dividends: (sum << frac) + total/2
  assign half_total = DIVD_W'(running_total >> 1);
  assign dvd_x = {weighted_x_sum, FRAC_BITS'(0)} + half_total;
  assign dvd_y = {weighted_y_sum, FRAC_BITS'(0)} + half_total;

  // one restoring step per lane
  assign trial_x = {rem_x, quo_x[CENT_W-1]};
  assign trial_y = {rem_y, quo_y[CENT_W-1]};
  assign ge_x    = trial_x >= {1'b0, div_total};
  assign ge_y    = trial_y >= {1'b0, div_total};
  assign diff_x  = trial_x - {1'b0, div_total};
  assign diff_y  = trial_y - {1'b0, div_total};

  // divider registers: remainder on top, dividend bits shifting out of quo
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_peak  <= running_peak;
      div_total <= running_total;
      rem_x     <= dvd_x[DIVD_W-1:CENT_W];
      rem_y     <= dvd_y[DIVD_W-1:CENT_W];
      quo_x     <= dvd_x[CENT_W-1:0];
      quo_y     <= dvd_y[CENT_W-1:0];
    end else if (cmd.step) begin
      rem_x <= ge_x ? diff_x[TOTAL_W-1:0] : trial_x[TOTAL_W-1:0];
      rem_y <= ge_y ? diff_y[TOTAL_W-1:0] : trial_y[TOTAL_W-1:0];
      quo_x <= {quo_x[CENT_W-2:0], ge_x};
      quo_y <= {quo_y[CENT_W-2:0], ge_y};
    end
  end

  // result register, centroid forced to zero on an empty frame
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      peak_force  <= div_peak;
      total_force <= div_total;
      empty_frame <= (div_total == '0);
      centroid_x  <= (div_total == '0) ? '0 : quo_x;
      centroid_y  <= (div_total == '0) ? '0 : quo_y;
    end
  end

endmodule

`default_nettype wire

[sv/pfc_ctrl.sv]
// pfc_ctrl: sequencer for accumulate, divider load, division steps and result handoff
`default_nettype none

module pfc_ctrl
  import pfc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire pfc_sts_t sts,
  output pfc_cmd_t      cmd
);

  pfc_state_t        state;
  pfc_state_t        state_next;
  logic [STEP_W-1:0] step_count;
  logic [STEP_W-1:0] step_count_next;
  logic              out_valid_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACCUM;
      step_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      step_count <= step_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    step_count_next = step_count;
    in_ready        = 1'b0;
    cmd             = '0;
    case (state)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.last_cell) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load        = 1'b1;
        step_count_next = '0;
        state_next      = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (step_count == STEP_W'(CENT_W - 1)) begin
          step_count_next = '0;
          state_next      = ST_HOLD;
        end else begin
          step_count_next = step_count + STEP_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  // result beat held until taken
  always_comb begin
    if (cmd.publish) out_valid_next = 1'b1;
    else             out_valid_next = out_valid && !out_ready;
  end

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result register overwritten while still held");

  // the frame's last beat starts the divider load
  a_last_to_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCUM && in_valid && sts.last_cell) |=> (state == ST_LOAD))
    else $error("frame end did not start the division");

  // step counter only moves while dividing
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIV) |-> (step_count == '0))
    else $error("division step counter active outside division");

  // no sample taken while the dividers are busy
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD || state == ST_DIV) |-> !cmd.accept)
    else $error("sample accepted during division");

endmodule

`default_nettype wire

[sv/pressure_frame_centroid.sv]
// pressure_frame_centroid: peak, total and force-weighted centroid of a pressure-pad frame
// Throughput: one force sample per cycle while a frame streams in.
// After the last cell of a frame the input stalls while the two restoring dividers load,
//   CENT_W division steps run and the publish follows,
//   which waits until the previous result beat has been taken.
// Reset (rst, synchronous): counters and accumulators clear, limits return to 64 x 64.
`default_nettype none

module pressure_frame_centroid
  import pfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  pfc_sample_if.sink                sample_in,
  pfc_result_if.source              result_out
);

  pfc_cmd_t cmd;
  pfc_sts_t sts;

  // sequencer
  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // accumulators, dividers, result register
  pfc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .force_sample (sample_in.force_sample),
    .cmd          (cmd),
    .sts          (sts),
    .peak_force   (result_out.peak_force),
    .total_force  (result_out.total_force),
    .centroid_x   (result_out.centroid_x),
    .centroid_y   (result_out.centroid_y),
    .empty_frame  (result_out.empty_frame)
  );

endmodule

`default_nettype wire

[bench/tb.sv]
// tb: self-checking testbench for pressure_frame_centroid, per-frame peak, total and centroid
module tb
  import pfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FORCE_BITS-1:0] peak;
    logic [TOTAL_W-1:0]    total;
    logic [CENT_W-1:0]     cent_x;
    logic [CENT_W-1:0]     cent_y;
    logic                  empty;
  } frame_result_t;

  typedef enum int {MIX_FULL, MIX_SPARSE, MIX_EXTREME, MIX_LOW} level_mix_t;

  localparam logic [FORCE_BITS-1:0] LEVEL_MAX = {FORCE_BITS{1'b1}};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  pfc_sample_if sample_in ();
  pfc_result_if result_out ();

  pressure_frame_centroid dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in (sample_in),
    .result_out(result_out)
  );

  // frame predictor state
  logic [CFG_W-1:0]      cols_cfg;
  logic [CFG_W-1:0]      rows_cfg;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [FORCE_BITS-1:0] peak_acc;
  logic [TOTAL_W-1:0]    total_acc;
  logic [WSUM_W-1:0]     wx_acc;
  logic [WSUM_W-1:0]     wy_acc;

  frame_result_t pending_frames[$];
  frame_result_t due_frame;
  frame_result_t seen_frame;
  int            mismatch_count = 0;
  bit            idle_en = 1'b1;
  int            stall_left = 0;

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // overall time limit
  initial begin
    #3_000_000;
    $display("pressure_frame_centroid verification failed");
    $finish;
  end

  // result side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_out.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= 1'b1;
    end
  end

  // compare each result beat against the oldest predicted frame
  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      seen_frame = {result_out.peak_force, result_out.total_force, result_out.centroid_x,
                    result_out.centroid_y, result_out.empty_frame};
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected frame result: peak=%0d total=%0d cx=%0d cy=%0d empty=%0b",
                   seen_frame.peak, seen_frame.total, seen_frame.cent_x, seen_frame.cent_y,
                   seen_frame.empty);
      end else begin
        due_frame = pending_frames.pop_front();
        if (seen_frame !== due_frame) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("frame mismatch: expected peak=%0d total=%0d cx=%0d cy=%0d empty=%0b",
                     due_frame.peak, due_frame.total, due_frame.cent_x, due_frame.cent_y,
                     due_frame.empty);
            $display("                got peak=%0d total=%0d cx=%0d cy=%0d empty=%0b",
                     seen_frame.peak, seen_frame.total, seen_frame.cent_x,
                     seen_frame.cent_y, seen_frame.empty);
          end
        end
      end
    end
  end

  // register value 0 acts as 1, anything above the maximum as the maximum
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // (wsum * 2^frac + total/2) / total, zero for an empty frame
  function automatic logic [CENT_W-1:0] rounded_centroid(input logic [WSUM_W-1:0] wsum,
                                                         input logic [TOTAL_W-1:0] total);
    logic [63:0] num;
    if (total == 0) return '0;
    num = (64'(wsum) << FRAC_BITS) + 64'(total >> 1);
    return CENT_W'(num / 64'(total));
  endfunction

  function automatic void clear_frame_sums();
    col_pos   = 0;
    row_pos   = 0;
    peak_acc  = '0;
    total_acc = '0;
    wx_acc    = '0;
    wy_acc    = '0;
  endfunction

  // fold one accepted sample into the frame sums, queue a result at the frame end
  function automatic void accumulate_cell(input logic [FORCE_BITS-1:0] level);
    frame_result_t r;
    int unsigned   cols;
    int unsigned   rows;
    cols = clamp_dim(cols_cfg, MAX_COLS);
    rows = clamp_dim(rows_cfg, MAX_ROWS);
    if (level > peak_acc) peak_acc = level;
    total_acc = total_acc + TOTAL_W'(level);
    wx_acc = wx_acc + WSUM_W'(col_pos) * WSUM_W'(level);
    wy_acc = wy_acc + WSUM_W'(row_pos) * WSUM_W'(level);
    if (col_pos + 1 < cols) begin
      col_pos++;
      return;
    end
    col_pos = 0;
    if (row_pos + 1 < rows) begin
      row_pos++;
      return;
    end
    r.peak   = peak_acc;
    r.total  = total_acc;
    r.cent_x = rounded_centroid(wx_acc, total_acc);
    r.cent_y = rounded_centroid(wy_acc, total_acc);
    r.empty  = (total_acc == 0);
    pending_frames = {pending_frames, r};
    clear_frame_sums();
  endfunction

  // one sample beat, with an occasional idle burst ahead of it
  task automatic send_sample(input logic [FORCE_BITS-1:0] level);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      sample_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    sample_in.valid <= 1'b1;
    sample_in.force_sample <= level;
    @(posedge clk);
    while (!sample_in.ready) @(posedge clk);
    accumulate_cell(level);
    @(negedge clk);
  endtask

  // drain all results, then let the dividers settle
  task automatic wait_idle();
    sample_in.valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (CENT_W + 8) @(negedge clk);
  endtask

  task automatic set_frame_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_COLS;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_index <= REG_FRAME_ROWS;
    cfg_data  <= rows;
    @(negedge clk);
    cfg_we <= 1'b0;
    cols_cfg = cols;
    rows_cfg = rows;
  endtask

  function automatic logic [FORCE_BITS-1:0] random_level(input level_mix_t mix);
    case (mix)
      MIX_SPARSE:  return ($urandom_range(0, 7) == 0) ? FORCE_BITS'($urandom) : '0;
      MIX_EXTREME: return ($urandom_range(0, 1) == 0) ? LEVEL_MAX : '0;
      MIX_LOW:     return FORCE_BITS'($urandom_range(0, 15));
      default:     return FORCE_BITS'($urandom);
    endcase
  endfunction

  // mostly small frames, sometimes clamped or full-size limits
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return CFG_W'($urandom_range(65, 127));
    if (pick == 2) return CFG_W'(64);
    if (pick <= 5) return CFG_W'($urandom_range(9, 20));
    return CFG_W'($urandom_range(1, 8));
  endfunction

  // reset limits of 64 x 64, every sample at full scale
  task automatic test_full_default_frame();
    repeat (MAX_COLS * MAX_ROWS) send_sample(LEVEL_MAX);
  endtask

  // one-cell frames: empty, full scale, smallest nonzero, bit patterns
  task automatic test_single_cell();
    set_frame_size(1, 1);
    send_sample('0);
    send_sample(LEVEL_MAX);
    send_sample(1);
    send_sample(12'h555);
    send_sample(12'hAAA);
  endtask

  // centroid rounding, ties going up, and the all-zero frame
  task automatic test_rounding();
    set_frame_size(2, 1);
    send_sample(511);
    send_sample(1);
    send_sample('0);
    send_sample('0);
    set_frame_size(3, 2);
    send_sample(1);
    send_sample(0);
    send_sample(2);
    repeat (3) send_sample('0);
    repeat (5) send_sample('0);
    send_sample(7);
  endtask

  // zero and oversized limits; the far corner gives the largest centroid
  task automatic test_register_clamp();
    set_frame_size(0, 127);
    repeat (MAX_ROWS - 1) send_sample('0);
    send_sample(LEVEL_MAX);
    set_frame_size(127, 0);
    repeat (MAX_COLS - 1) send_sample('0);
    send_sample(LEVEL_MAX);
  endtask

  // limits shrink under a partly received frame
  task automatic test_mid_frame_resize();
    set_frame_size(8, 8);
    repeat (20) send_sample(random_level(MIX_FULL));
    set_frame_size(3, 8);
    repeat (5) send_sample(random_level(MIX_FULL));
    set_frame_size(3, 2);
    send_sample(random_level(MIX_FULL));
    repeat (6) send_sample(random_level(MIX_FULL));
  endtask

  // random limits and sample mixes, mostly whole frames
  task automatic test_random_frames();
    int          sent;
    int          n;
    int unsigned frame_cells;
    level_mix_t  mix;
    sent = 0;
    while (sent < 1000) begin
      idle_en = ($urandom_range(0, 3) != 0);
      set_frame_size(pick_dim(), pick_dim());
      mix = level_mix_t'($urandom_range(0, 3));
      frame_cells = clamp_dim(cols_cfg, MAX_COLS) * clamp_dim(rows_cfg, MAX_ROWS);
      if (frame_cells <= 16 && $urandom_range(0, 3) != 0)
        n = frame_cells * $urandom_range(1, 4);
      else
        n = $urandom_range(10, 60);
      repeat (n) send_sample(random_level(mix));
      sent += n;
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_back_to_back();
    idle_en = 1'b0;
    set_frame_size(4, 3);
    repeat (240) send_sample(random_level(MIX_FULL));
    set_frame_size(1, 1);
    repeat (30) send_sample(random_level(MIX_FULL));
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = REG_FRAME_COLS;
    cfg_data               = '0;
    sample_in.valid        = 1'b0;
    sample_in.force_sample = '0;
    result_out.ready       = 1'b0;
    cols_cfg               = CFG_W'(64);
    rows_cfg               = CFG_W'(64);
    clear_frame_sums();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_full_default_frame();
    test_single_cell();
    test_rounding();
    test_register_clamp();
    test_mid_frame_resize();
    test_random_frames();
    test_back_to_back();

    wait_idle();
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("pressure_frame_centroid verification clean");
    end else begin
      $display("pressure_frame_centroid verification failed");
    end
    $finish;
  end

endmodule
